/* hw/rtl/mhpf_pkg.sv */
// Shared constants, opcodes and state type of the multi-resolution hit pattern block.
package mhpf_pkg;

    localparam int LEVELS          = 10;
    localparam int NPLANES         = 8;
    localparam int WORD_BITS       = 64;
    localparam int BIT_SEL_W       = $clog2(WORD_BITS);
    localparam int PLANE_BITS      = 1 << LEVELS;
    localparam int WORDS_PER_PLANE = PLANE_BITS / WORD_BITS;
    localparam int WSEL_W          = $clog2(WORDS_PER_PLANE);
    localparam int PLANE_W         = 3;
    localparam int MEM_DEPTH       = NPLANES * WORDS_PER_PLANE;
    localparam int ADDR_W          = PLANE_W + WSEL_W;
    localparam int IDX_W           = LEVELS;
    localparam int BIN_W           = LEVELS - 1;
    localparam int LEVEL_W         = 4;
    localparam int READ_BIN_W      = 9;
    localparam int POS_W           = 32;
    localparam int SCALE_W         = 32;
    localparam int FINE_BINS       = 1 << (LEVELS - 1);

    // Input item layout inside s_axis_tdata, lowest field first.
    localparam int OPC_LSB   = 0;
    localparam int PLANE_LSB = OPC_LSB + 2;
    localparam int START_LSB = PLANE_LSB + PLANE_W;
    localparam int END_LSB   = START_LSB + POS_W;
    localparam int LEVEL_LSB = END_LSB + POS_W;
    localparam int BIN_LSB   = LEVEL_LSB + LEVEL_W;
    localparam int IN_BITS   = BIN_LSB + READ_BIN_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [1:0] {
        OP_MARK  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_HI,
        S_MUL_LO,
        S_CHECK,
        S_LEVEL,
        S_RD,
        S_WR,
        S_CLEAR,
        S_RBIT_ADDR,
        S_RBIT_DATA,
        S_DONE
    } t_state;

endpackage

/* hw/rtl/multires_hit_pattern_fill.sv */
// Multi-resolution hit pattern store with mark, clear-all and bit-read requests.
//
// Usage: requests enter on the s_axis channel (opcode, plane, start and end
// position, read level and bin packed in s_axis_tdata); every request yields
// exactly one response on m_axis (bit_value, mark_dropped). The bin scale is
// written through the i_cfg channel, which is always ready; write it only
// while no request is in flight.
// The patterns of all planes live in one 128 x 64 synchronous RAM. A per-word
// valid flag marks words written since the last clear, so a clear request
// only resets the flags and reset needs no sweep of the RAM.
// Each request ends in the done state, which loads its response. A clear
// first passes the clear state, a valid read an address and a data state;
// other opcodes and invalid reads go straight to done. A mark runs the two
// position multiplies and the range check, then per tree level a level step
// and, for each pattern word the level touches, a RAM read and then a write
// back; this read-modify-write of the RAM works one word at a time.
// One request is processed at a time. A finished response waits in an output
// register, and the next request is accepted while it waits; if the receiver
// stalls, the following response holds the block until the register is free.
// Reset empties all patterns and sets the bin scale to 1.0.
module multires_hit_pattern_fill (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mhpf_pkg::SCALE_W-1:0]       i_cfg_data,    // bin_scale
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // opcode, plane_index, range_start, range_end, read_level, read_bin, zero pad
    input  logic [mhpf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // bit_value, mark_dropped, zero pad
    output logic [mhpf_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import mhpf_pkg::*;

    localparam logic signed [POS_W-1:0] FINE_BINS_S = POS_W'(FINE_BINS);

    // Pattern RAM and its per-word valid flags.
    logic [WORD_BITS-1:0] mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_valid, n_valid;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rd_valid;

    t_state r_state, n_state;

    logic [SCALE_W-1:0]        r_bin_scale;
    logic [PLANE_W-1:0]        r_plane, n_plane;
    logic signed [POS_W-1:0]   r_start, n_start;
    logic signed [POS_W-1:0]   r_end, n_end;
    logic signed [63:0]        r_prod;
    logic signed [POS_W-1:0]   r_hi_bin, n_hi_bin;
    logic [BIN_W-1:0]          r_lo, n_lo;
    logic [BIN_W-1:0]          r_hi, n_hi;
    logic [LEVEL_W-1:0]        r_level, n_level;
    logic [WSEL_W-1:0]         r_word, n_word;
    logic [BIT_SEL_W-1:0]      r_bitsel, n_bitsel;
    logic                      r_res_bit, n_res_bit;
    logic                      r_res_drop, n_res_drop;
    logic                      r_out_valid, n_out_valid;
    logic                      r_out_bit, n_out_bit;
    logic                      r_out_drop, n_out_drop;

    // Input field views.
    t_opcode                 w_in_op;
    logic [PLANE_W-1:0]      w_in_plane;
    logic [LEVEL_W-1:0]      w_in_level;
    logic [READ_BIN_W-1:0]   w_in_bin;
    logic                    w_in_read_ok;
    logic [IDX_W-1:0]        w_in_idx;
    logic                    w_accept;

    logic signed [POS_W-1:0] w_mul_pos;
    logic signed [64:0]      w_mul_full;
    logic signed [POS_W-1:0] w_lo_bin;
    logic                    w_drop;

    logic [IDX_W-1:0]        w_lvl_one;
    logic [IDX_W-1:0]        w_idx_lo, w_idx_hi;
    logic [WSEL_W-1:0]       w_lo_word, w_hi_word;
    logic [WORD_BITS-1:0]    w_mask;
    logic [ADDR_W-1:0]       w_mem_addr;
    logic                    w_out_free;

    assign w_in_op    = t_opcode'(s_axis_tdata[OPC_LSB +: 2]);
    assign w_in_plane = s_axis_tdata[PLANE_LSB +: PLANE_W];
    assign w_in_level = s_axis_tdata[LEVEL_LSB +: LEVEL_W];
    assign w_in_bin   = s_axis_tdata[BIN_LSB +: READ_BIN_W];
    assign w_in_read_ok = ({1'b0, w_in_plane} < (PLANE_W+1)'(NPLANES)) &&
                          (32'(w_in_level) < 32'(LEVELS)) &&
                          (32'(w_in_bin) < (32'd1 << w_in_level));
    assign w_in_idx = (IDX_W'(1) << w_in_level) | IDX_W'(w_in_bin);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // One multiplier, shared by the end and the start position.
    assign w_mul_pos  = (r_state == S_MUL_HI) ? r_end : r_start;
    assign w_mul_full = w_mul_pos * $signed({1'b0, r_bin_scale});
    // Arithmetic shift by 32 of the exact product is the floor of the bin.
    assign w_lo_bin   = r_prod[63:32];
    assign w_drop     = ({1'b0, r_plane} >= (PLANE_W+1)'(NPLANES)) ||
                        (r_hi_bin < 0) || (w_lo_bin >= FINE_BINS_S);

    // Bit range of the current level inside the plane, and its word mask.
    assign w_lvl_one = IDX_W'(1) << r_level;
    assign w_idx_lo  = w_lvl_one | IDX_W'(r_lo);
    assign w_idx_hi  = w_lvl_one | IDX_W'(r_hi);
    assign w_lo_word = w_idx_lo[IDX_W-1:BIT_SEL_W];
    assign w_hi_word = w_idx_hi[IDX_W-1:BIT_SEL_W];
    assign w_mask = ((r_word == w_lo_word) ? ({WORD_BITS{1'b1}} << w_idx_lo[BIT_SEL_W-1:0])
                                           : {WORD_BITS{1'b1}}) &
                    ((r_word == w_hi_word) ? ({WORD_BITS{1'b1}} >> ~w_idx_hi[BIT_SEL_W-1:0])
                                           : {WORD_BITS{1'b1}});

    assign w_mem_addr = {r_plane, r_word};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (w_in_op)
                        OP_MARK:  n_state = S_MUL_HI;
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_READ:  n_state = w_in_read_ok ? S_RBIT_ADDR : S_DONE;
                        OP_NOP:   n_state = S_DONE;
                    endcase
                end
            end
            S_MUL_HI:    n_state = S_MUL_LO;
            S_MUL_LO:    n_state = S_CHECK;
            S_CHECK:     n_state = w_drop ? S_DONE : S_LEVEL;
            S_LEVEL: begin
                if (r_lo <= r_hi) begin
                    n_state = S_RD;
                end else if (r_level == '0) begin
                    n_state = S_DONE;
                end
            end
            S_RD:        n_state = S_WR;
            S_WR: begin
                if (r_word != w_hi_word) begin
                    n_state = S_RD;
                end else if (r_level == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_LEVEL;
                end
            end
            S_CLEAR:     n_state = S_DONE;
            S_RBIT_ADDR: n_state = S_RBIT_DATA;
            S_RBIT_DATA: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath and output next values.
    always_comb begin
        n_plane     = r_plane;
        n_start     = r_start;
        n_end       = r_end;
        n_hi_bin    = r_hi_bin;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_level     = r_level;
        n_word      = r_word;
        n_bitsel    = r_bitsel;
        n_res_bit   = r_res_bit;
        n_res_drop  = r_res_drop;
        n_valid     = r_valid;
        n_out_valid = r_out_valid;
        n_out_bit   = r_out_bit;
        n_out_drop  = r_out_drop;

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_plane    = w_in_plane;
                    n_start    = s_axis_tdata[START_LSB +: POS_W];
                    n_end      = s_axis_tdata[END_LSB +: POS_W];
                    n_word     = w_in_idx[IDX_W-1:BIT_SEL_W];
                    n_bitsel   = w_in_idx[BIT_SEL_W-1:0];
                    n_res_bit  = 1'b0;
                    n_res_drop = 1'b0;
                end
            end
            S_MUL_LO: n_hi_bin = r_prod[63:32];
            S_CHECK: begin
                n_res_drop = w_drop;
                n_lo = (w_lo_bin < 0) ? '0 : w_lo_bin[BIN_W-1:0];
                n_hi = (r_hi_bin >= FINE_BINS_S) ? BIN_W'(FINE_BINS - 1)
                                                 : r_hi_bin[BIN_W-1:0];
                n_level = LEVEL_W'(LEVELS - 1);
            end
            S_LEVEL: begin
                if (r_lo <= r_hi) begin
                    n_word = w_lo_word;
                end else if (r_level != '0) begin
                    n_lo    = r_lo >> 1;
                    n_hi    = r_hi >> 1;
                    n_level = r_level - 1'b1;
                end
            end
            S_WR: begin
                n_valid[w_mem_addr] = 1'b1;
                if (r_word != w_hi_word) begin
                    n_word = r_word + 1'b1;
                end else if (r_level != '0) begin
                    n_lo    = r_lo >> 1;
                    n_hi    = r_hi >> 1;
                    n_level = r_level - 1'b1;
                end
            end
            S_CLEAR: n_valid = '0;
            S_RBIT_DATA: n_res_bit = r_rd_valid & r_rdata[r_bitsel];
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_res_bit;
                    n_out_drop  = r_res_drop;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_bin_scale <= SCALE_W'(65536);
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bin_scale <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_plane    <= n_plane;
        r_start    <= n_start;
        r_end      <= n_end;
        r_prod     <= w_mul_full[63:0];
        r_hi_bin   <= n_hi_bin;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_level    <= n_level;
        r_word     <= n_word;
        r_bitsel   <= n_bitsel;
        r_res_bit  <= n_res_bit;
        r_res_drop <= n_res_drop;
        r_out_bit  <= n_out_bit;
        r_out_drop <= n_out_drop;
    end

    // Pattern RAM: registered read every cycle, write back in the write state.
    // A word that has not been written since the last clear reads as zero.
    always_ff @(posedge i_clk) begin
        r_rdata    <= mem[w_mem_addr];
        r_rd_valid <= r_valid[w_mem_addr];
        if (r_state == S_WR) begin
            mem[w_mem_addr] <= (r_rd_valid ? r_rdata : '0) | w_mask;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, r_out_drop, r_out_bit};

    // A word is written back only for a non-empty range at the current level.
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (r_lo <= r_hi) &&
                              (r_word >= w_lo_word) && (r_word <= w_hi_word))
        else $error("write-back outside the level's word range");

    // The written word is flagged valid right after the write.
    a_wr_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |=> r_valid[$past(w_mem_addr)])
        else $error("written word not flagged valid");

    // A clear request leaves every word empty.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (r_valid == '0))
        else $error("valid flags not cleared");

    // A response is loaded only into a free output register.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_out_valid && !m_axis_tready |=> (r_state == S_DONE))
        else $error("response overwrote a pending one");

endmodule

/* test/mhpf_checker.sv */
// Response checker for the hit pattern block: tracks the pattern state and compares responses.
module mhpf_checker
    import mhpf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [SCALE_W-1:0]    i_cfg_data,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [IN_DATA_W-1:0]  i_req_data,
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    input  logic [OUT_DATA_W-1:0] i_rsp_data,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_responses,
    output int                    o_drops,
    output int                    o_read_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [SCALE_W-1:0] SCALE_AT_RESET = 32'h0001_0000;
    localparam int                 REPORT_LIMIT   = 10;

    typedef struct packed {
        logic mark_dropped;
        logic bit_value;
    } t_response;

    logic [PLANE_BITS-1:0] hit_tree [NPLANES];
    logic [SCALE_W-1:0]    bin_scale = SCALE_AT_RESET;
    t_response             expected_rsp [$];
    int                    mismatches = 0;
    int                    responses  = 0;
    int                    drops      = 0;
    int                    read_hits  = 0;

    // Signed position times unsigned scale is exact in 64 bits; the shift floors.
    function automatic longint finest_bin(logic signed [POS_W-1:0] pos);
        longint prod;
        prod = longint'(pos) * longint'({32'd0, bin_scale});
        return prod >>> 32;
    endfunction

    // Sets the covered bins at every level and returns whether the mark was dropped.
    function automatic logic apply_mark(int plane, logic signed [POS_W-1:0] pos_start,
                                        logic signed [POS_W-1:0] pos_end);
        longint lo;
        longint hi;
        int     level_base;
        if (plane >= NPLANES) return 1'b1;
        lo = finest_bin(pos_start);
        hi = finest_bin(pos_end);
        if (hi < 0 || lo >= FINE_BINS) return 1'b1;
        if (lo < 0) lo = 0;
        if (hi >= FINE_BINS) hi = FINE_BINS - 1;
        level_base = FINE_BINS;
        for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
            for (longint b = lo; b <= hi; b++) begin
                hit_tree[plane][level_base + b] = 1'b1;
            end
            level_base = level_base >> 1;
            lo = lo >>> 1;
            hi = hi >>> 1;
        end
        return 1'b0;
    endfunction

    function automatic t_response predict_response(logic [IN_DATA_W-1:0] req);
        t_opcode   op;
        int        plane;
        int        lvl;
        int        bin;
        t_response rsp;
        op    = t_opcode'(req[OPC_LSB +: 2]);
        plane = int'(req[PLANE_LSB +: PLANE_W]);
        lvl   = int'(req[LEVEL_LSB +: LEVEL_W]);
        bin   = int'(req[BIN_LSB +: READ_BIN_W]);
        rsp   = '0;
        case (op)
            OP_MARK: begin
                rsp.mark_dropped = apply_mark(plane, req[START_LSB +: POS_W],
                                              req[END_LSB +: POS_W]);
            end
            OP_CLEAR: begin
                foreach (hit_tree[p]) hit_tree[p] = '0;
            end
            OP_READ: begin
                if (plane < NPLANES && lvl < LEVELS && bin < (1 << lvl))
                    rsp.bit_value = hit_tree[plane][(1 << lvl) + bin];
            end
            default: ;
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_response got;
        t_response want;
        if (!i_rst_n) begin
            foreach (hit_tree[p]) hit_tree[p] = '0;
            bin_scale = SCALE_AT_RESET;
            expected_rsp.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) bin_scale = i_cfg_data;
            if (i_rsp_valid && i_rsp_ready) begin
                got = t_response'(i_rsp_data[1:0]);
                responses++;
                if (got.mark_dropped) drops++;
                if (got.bit_value) read_hits++;
                if (expected_rsp.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("[%0t] response %0d arrived with no request outstanding",
                                 $realtime, responses);
                    mismatches++;
                end else begin
                    want = expected_rsp.pop_front();
                    if (got != want) begin
                        if (mismatches < REPORT_LIMIT)
                            $display("[%0t] rsp %0d: bit exp %0b got %0b, drop exp %0b got %0b",
                                     $realtime, responses,
                                     want.bit_value, got.bit_value,
                                     want.mark_dropped, got.mark_dropped);
                        mismatches++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                expected_rsp.insert(expected_rsp.size(), predict_response(i_req_data));
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_rsp.size();
        o_responses  <= responses;
        o_drops      <= drops;
        o_read_hits  <= read_hits;
    end

endmodule

/* test/tb_top.sv */
// Top-level testbench for the hit pattern block: clock, reset, request stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mhpf_pkg::*;

    localparam int PHASES           = 6;
    localparam int RANDOM_PER_PHASE = 250;
    localparam int HOLD_CYCLES      = 400;
    localparam int STALL_LIMIT      = 5000;
    localparam int DRAIN_CYCLES     = 64;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [SCALE_W-1:0]    i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int mismatches;
    int pending;
    int responses;
    int drops;
    int read_hits;

    int                 src_idle_pct   = 0;
    int                 sink_stall_pct = 0;
    logic               hold_request   = 1'b0;
    logic               hold_served    = 1'b0;
    int                 hold_left      = 0;
    int                 quiet_cycles   = 0;
    int                 requests_sent  = 0;
    logic [SCALE_W-1:0] cur_scale      = 32'h0001_0000;
    int                 last_plane     = 0;
    int                 last_bin       = 0;

    logic [SCALE_W-1:0] phase_scale [PHASES] = '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                                                 32'h0010_0000, 32'h0000_1000, 32'h0003_8E39};
    int                 phase_idle  [PHASES] = '{0, 72, 0, 23, 72, 0};
    int                 phase_stall [PHASES] = '{0, 0, 72, 23, 0, 72};

    multires_hit_pattern_fill DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mhpf_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_rsp_valid  (m_axis_tvalid),
        .i_rsp_ready  (m_axis_tready),
        .i_rsp_data   (m_axis_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_responses  (responses),
        .o_drops      (drops),
        .o_read_hits  (read_hits)
    );

    always #4 i_clk = ~i_clk;

    // Response side: random stalls, plus one long hold-off that backs the block up.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_request && !hold_served) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_served   <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_request(
            t_opcode op, logic [PLANE_W-1:0] plane, logic [POS_W-1:0] pos_start,
            logic [POS_W-1:0] pos_end, logic [LEVEL_W-1:0] lvl, logic [READ_BIN_W-1:0] bin);
        logic [IN_DATA_W-1:0] req;
        req                       = '0;
        req[OPC_LSB +: 2]         = op;
        req[PLANE_LSB +: PLANE_W] = plane;
        req[START_LSB +: POS_W]   = pos_start;
        req[END_LSB +: POS_W]     = pos_end;
        req[LEVEL_LSB +: LEVEL_W] = lvl;
        req[BIN_LSB +: READ_BIN_W] = bin;
        return req;
    endfunction

    // Position that falls inside the given finest-level bin under the current scale.
    function automatic logic [POS_W-1:0] position_in_bin(int target);
        longint unit;
        longint pos;
        if (cur_scale == '0) return $urandom;
        unit = 64'sd4294967296 / longint'({32'd0, cur_scale});
        pos  = longint'(target) * unit + longint'($urandom) % unit;
        if (pos > 64'sd2147483647) pos = 64'sd2147483647;
        if (pos < -64'sd2147483648) pos = -64'sd2147483648;
        return pos[POS_W-1:0];
    endfunction

    // Valid stays high between back-to-back requests; it drops only for an idle gap.
    task automatic send_request(t_opcode op, logic [PLANE_W-1:0] plane,
                                logic [POS_W-1:0] pos_start, logic [POS_W-1:0] pos_end,
                                logic [LEVEL_W-1:0] lvl, logic [READ_BIN_W-1:0] bin);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_request(op, plane, pos_start, pos_end, lvl, bin);
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_scale(logic [SCALE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_scale = value;
    endtask

    task automatic send_random_request();
        int                   pick;
        int                   lo_bin;
        int                   span;
        int                   lvl;
        int                   bin;
        logic [PLANE_W-1:0]   plane;
        logic [POS_W-1:0]     pos_start;
        logic [POS_W-1:0]     pos_end;
        logic [POS_W-1:0]     swap;
        pick  = int'($urandom_range(99));
        plane = PLANE_W'($urandom);
        if (pick < 48) begin
            if ($urandom_range(99) < 85) begin
                lo_bin    = int'($urandom_range(FINE_BINS + 15)) - 8;
                span      = ($urandom_range(9) == 0) ? int'($urandom_range(FINE_BINS + 40))
                                                     : int'($urandom_range(2));
                pos_start = position_in_bin(lo_bin);
                pos_end   = position_in_bin(lo_bin + span);
                // Now and then the range comes in reversed.
                if ($urandom_range(19) == 0) begin
                    swap      = pos_start;
                    pos_start = pos_end;
                    pos_end   = swap;
                end
                last_plane = int'(plane);
                last_bin   = (lo_bin < 0) ? 0 : (lo_bin >= FINE_BINS) ? FINE_BINS - 1 : lo_bin;
            end else begin
                pos_start = $urandom;
                pos_end   = $urandom;
            end
            send_request(OP_MARK, plane, pos_start, pos_end, LEVEL_W'($urandom),
                         READ_BIN_W'($urandom));
        end else if (pick < 90) begin
            if ($urandom_range(9) < 8) begin
                lvl = int'($urandom_range(LEVELS - 1));
                if ($urandom_range(1) == 0) begin
                    plane = PLANE_W'(last_plane);
                    bin   = last_bin >> (LEVELS - 1 - lvl);
                end else begin
                    bin = int'($urandom_range((1 << lvl) - 1));
                end
            end else begin
                lvl = int'($urandom_range(15));
                bin = int'($urandom_range(511));
            end
            send_request(OP_READ, plane, $urandom, $urandom, LEVEL_W'(lvl), READ_BIN_W'(bin));
        end else if (pick < 94) begin
            send_request(OP_CLEAR, plane, $urandom, $urandom, LEVEL_W'($urandom),
                         READ_BIN_W'($urandom));
        end else begin
            send_request(OP_NOP, plane, $urandom, $urandom, LEVEL_W'($urandom),
                         READ_BIN_W'($urandom));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests at the reset scale of one bin per position unit.
        send_request(OP_READ, 3'd0, 32'h0, 32'h0, 4'd0, 9'd0);
        send_request(OP_MARK, 3'd0, 32'h0000_0000, 32'h0000_0000, 4'd0, 9'd0);
        send_request(OP_READ, 3'd0, 32'h0, 32'h0, 4'd9, 9'd0);
        send_request(OP_READ, 3'd0, 32'h0, 32'h0, 4'd0, 9'd0);
        send_request(OP_MARK, 3'd7, 32'h01FF_0000, 32'h01FF_FFFF, 4'd0, 9'd0);
        send_request(OP_READ, 3'd7, 32'h0, 32'h0, 4'd9, 9'd511);
        // Ranges wholly below and wholly above the detector.
        send_request(OP_MARK, 3'd1, 32'hFFFB_0000, 32'hFFFF_FFFF, 4'd0, 9'd0);
        send_request(OP_MARK, 3'd1, 32'h0200_0000, 32'h0258_0000, 4'd0, 9'd0);
        send_request(OP_READ, 3'd1, 32'h0, 32'h0, 4'd0, 9'd0);
        // A range that spills over both ends gets clamped.
        send_request(OP_MARK, 3'd3, 32'hFF9C_0000, 32'h03E8_0000, 4'd0, 9'd0);
        send_request(OP_READ, 3'd3, 32'h0, 32'h0, 4'd9, 9'd300);
        // Start after end: nothing at the finest level, bins meet one level up.
        send_request(OP_MARK, 3'd2, 32'h0009_0000, 32'h0008_0000, 4'd0, 9'd0);
        send_request(OP_READ, 3'd2, 32'h0, 32'h0, 4'd8, 9'd4);
        send_request(OP_READ, 3'd2, 32'h0, 32'h0, 4'd9, 9'd8);
        send_request(OP_MARK, 3'd4, 32'h8000_0000, 32'h7FFF_FFFF, 4'd0, 9'd0);
        send_request(OP_READ, 3'd4, 32'h0, 32'h0, 4'd9, 9'd511);
        // Reads outside the tree return zero.
        send_request(OP_READ, 3'd4, 32'h0, 32'h0, 4'd10, 9'd0);
        send_request(OP_READ, 3'd4, 32'h0, 32'h0, 4'd15, 9'd511);
        send_request(OP_READ, 3'd4, 32'h0, 32'h0, 4'd3, 9'd8);
        send_request(OP_NOP, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 9'd511);
        send_request(OP_CLEAR, 3'd0, 32'h0, 32'h0, 4'd0, 9'd0);
        send_request(OP_READ, 3'd3, 32'h0, 32'h0, 4'd0, 9'd0);
        send_request(OP_READ, 3'd4, 32'h0, 32'h0, 4'd9, 9'd511);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_until_drained();
            write_scale(phase_scale[ph]);
            src_idle_pct = phase_idle[ph];
            sink_stall_pct <= phase_stall[ph];
            hold_request   <= (ph == 0);
            repeat (RANDOM_PER_PHASE) send_random_request();
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests across %0d bin scale settings, zero and full scale included.",
                 requests_sent, PHASES);
        $display("Checked %0d responses: %0d dropped marks, %0d reads of a set bit.",
                 responses, drops, read_hits);
        if (mismatches == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
